>>> design/assert_macros.svh
// Assertion macros for the design files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never hold on a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> design/ias_pkg.sv
// Types, widths and codes for the insertable array store.
`default_nettype none
package ias_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [1:0]               req_t;
  typedef logic [1:0]               status_t;

  localparam req_t REQ_APPEND = 2'd0;
  localparam req_t REQ_INSERT = 2'd1;
  localparam req_t REQ_READ   = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // Write command broadcast along the row of cells.
  typedef struct packed {
    logic             en;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] cnt;
  } ias_wr_t;

endpackage
`default_nettype wire

>>> design/ias_cell.sv
// One storage cell: holds a word, loads a new one or takes its lower neighbour's.
`default_nettype none
module ias_cell
  import ias_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  load,
  input  wire logic  shift,
  input  wire word_t din_value,
  input  wire word_t din_prev,
  output      word_t q
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (load) begin
      word_nxt = din_value;
    end else if (shift) begin
      word_nxt = din_prev;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule
`default_nettype wire

>>> design/ias_chain.sv
// Row of storage cells with per-cell write decode and the read select.
`default_nettype none
module ias_chain
  import ias_pkg::*;
(
  input  wire logic             clk,
  input  wire ias_wr_t          wr,
  input  wire word_t            wr_value,
  input  wire logic [IDX_W-1:0] rd_idx,
  output      word_t            rd_data
);

  word_t cell_q [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
    logic  load;
    logic  shift;
    word_t prev;

    // cells above the insert point, up to the current end, move up by one
    assign load  = wr.en && (wr.pos == IDX);
    assign shift = wr.en && (IDX > wr.pos) && (IDX <= wr.cnt);

    if (i == 0) begin : g_first
      assign prev = wr_value;
    end else begin : g_rest
      assign prev = cell_q[i-1];
    end

    ias_cell u_cell (
      .clk       (clk),
      .load      (load),
      .shift     (shift),
      .din_value (wr_value),
      .din_prev  (prev),
      .q         (cell_q[i])
    );
  end

  assign rd_data = cell_q[rd_idx];

endmodule
`default_nettype wire

>>> design/insertable_array_store_top.sv
// Top level of the insertable array store: request decode, count and result register.
// Usage
//   Input channel (in_*): one request beat carries req_type (append, insert,
//   read), position and a signed 32-bit value. Result channel (out_*): one
//   beat per request with read_data, the element count after the request,
//   and status (ok, full, position out of range).
// Throughput
//   The whole row of cells shifts at once on an insert, so a beat accepted
//   at one edge has its result registered on out_* after that edge, and a
//   new request can be taken every cycle while the result register is not
//   held full by a low out_ready.
// Reset
//   rst_n (synchronous, active low) empties the store and drops out_valid.
//   Cell contents are not cleared; only entries below the count are read.
// Stall
//   The result register holds its beat while out_ready is low; in_ready
//   stays high as long as the register is empty or being drained this cycle.
`default_nettype none
`include "assert_macros.svh"
module insertable_array_store_top
  import ias_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [POS_W-1:0]   in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [DATA_W-1:0] out_read_data,
  output      logic [COUNT_W-1:0] out_count,
  output      logic [1:0]         out_status
);

  logic             in_fire;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  word_t            out_read_data_r;
  word_t            out_read_data_nxt;
  logic [CNT_W-1:0] out_count_r;
  status_t          out_status_r;
  status_t          out_status_nxt;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  ias_wr_t          wr;
  word_t            rd_data;

  // result register parts the two sides; refill while it drains
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    wr.en             = 1'b0;
    wr.pos            = cnt_ext;
    wr.cnt            = cnt_ext;
    count_nxt         = count_r;
    out_read_data_nxt = '0;
    out_status_nxt    = ST_OK;
    unique case (in_req_type)
      REQ_APPEND: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          wr.en     = in_fire;
          count_nxt = count_r + 1'b1;
        end
      end
      REQ_INSERT: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          out_status_nxt = ST_RANGE;
        end else begin
          wr.en     = in_fire;
          wr.pos    = pos_ext;
          count_nxt = count_r + 1'b1;
        end
      end
      REQ_READ: begin
        if (pos_ext >= cnt_ext) begin
          out_read_data_nxt = '1;
          out_status_nxt    = ST_RANGE;
        end else begin
          out_read_data_nxt = rd_data;
        end
      end
      default: begin
        // unused request kind: no change, plain ok
        out_status_nxt = ST_OK;
      end
    endcase
  end

  ias_chain u_chain (
    .clk      (clk),
    .wr       (wr),
    .wr_value (in_value),
    .rd_idx   (IDX_W'(in_position)),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_read_data_r <= out_read_data_nxt;
      out_count_r     <= count_nxt;
      out_status_r    <= out_status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_count     = COUNT_W'(out_count_r);
  assign out_status    = out_status_r;

  `ASSERT_NEVER(a_count_bound, count_r > CNT_W'(CAPACITY))
  `ASSERT_CLK(a_full_holds, in_fire && full && in_req_type != REQ_READ |=> $stable(count_r))
  `ASSERT_CLK(a_read_ok, in_fire && in_req_type == REQ_READ && pos_ext < cnt_ext |=> out_status_r == ST_OK && out_valid_r)

endmodule
`default_nettype wire

>>> test/tb_insertable_array_store_top.sv
// Testbench for the insertable array store: directed and random requests, shadow store check.
`timescale 1ns / 100ps
module tb_insertable_array_store_top;
  import ias_pkg::*;

  // Kind 3 is not decoded by the block; it must answer ok with the count.
  localparam req_t  REQ_UNUSED  = 2'd3;
  localparam word_t MISS_WORD   = -1;
  localparam int    RANDOM_REQS = 1500;
  localparam int    HOLD_CYCLES = 300;   // one long receiver hold-off
  localparam int    IDLE_LIMIT  = 2000;  // cycles with no beat on either side

  typedef struct {
    word_t               data;
    logic [COUNT_W-1:0]  count;
    status_t             status;
  } reply_t;

  // Shadow copy of the store plus the replies it still owes.
  class store_shadow;
    word_t  cells[CAPACITY];
    int     fill;
    reply_t due_replies[$];
    int     faults;

    function new();
      fill   = 0;
      faults = 0;
    endfunction

    task report(string what, longint got, longint want);
      faults++;
      $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Applies one request to the shadow store and returns the reply it earns.
    function reply_t serve_request(req_t kind, logic [POS_W-1:0] pos, word_t val);
      reply_t r;
      r.data   = '0;
      r.status = ST_OK;
      case (kind)
        REQ_APPEND: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            cells[fill] = val;
            fill++;
          end
        end
        REQ_INSERT: begin
          // fullness wins over a bad position
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else if (int'(pos) > fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = fill; i > int'(pos); i--) cells[i] = cells[i-1];
            cells[pos] = val;
            fill++;
          end
        end
        REQ_READ: begin
          if (int'(pos) >= fill) begin
            r.data   = MISS_WORD;
            r.status = ST_RANGE;
          end else begin
            r.data = cells[pos];
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(fill);
      return r;
    endfunction

    function void note_request(req_t kind, logic [POS_W-1:0] pos, word_t val);
      due_replies = {due_replies, serve_request(kind, pos, val)};
    endfunction

    task check_reply(word_t data, logic [COUNT_W-1:0] cnt, status_t st);
      reply_t want;
      if (due_replies.size() == 0) begin
        report("beat with nothing due, status", st, 0);
      end else begin
        want = due_replies.pop_front();
        if (data !== want.data)  report("read_data", data, want.data);
        if (cnt !== want.count)  report("count", cnt, want.count);
        if (st !== want.status)  report("status", st, want.status);
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_req_type;
  logic [POS_W-1:0]   in_position;
  logic signed [DATA_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [DATA_W-1:0] out_read_data;
  logic [COUNT_W-1:0] out_count;
  logic [1:0]         out_status;

  store_shadow shadow = new();
  int          replies_seen = 0;
  int          idle_cycles  = 0;
  bit          long_hold_done = 1'b0;

  insertable_array_store_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_count     (out_count),
    .out_status    (out_status)
  );

  always #5 clk = ~clk;

  // Offers one request beat and returns at the edge where it is taken.
  // Must be called in the time step of a rising edge; valid is left high,
  // so back-to-back calls form a burst.
  task automatic send_request(req_t kind, logic [POS_W-1:0] pos, word_t val);
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (in_ready !== 1'b1);
    shadow.note_request(kind, pos, val);
  endtask

  // Random request steered by the current fill: writes are kept rare so the
  // store fills slowly and most of the run reads a partly filled array,
  // with the full-store rejections arriving late on.
  task automatic pick_request(output req_t kind, output logic [POS_W-1:0] pos,
                              output word_t val);
    word_t corner_words[4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1};
    int    roll;
    int    fill;
    fill = shadow.fill;
    roll = $urandom_range(99);
    val  = ($urandom_range(9) == 0) ? corner_words[$urandom_range(3)] : word_t'($urandom);
    pos  = POS_W'($urandom_range(127));
    if (roll < 3) begin
      kind = REQ_APPEND;
    end else if (roll < 7) begin
      kind = REQ_INSERT;
      if ($urandom_range(99) < 85) pos = POS_W'($urandom_range(fill, 0));
    end else if (roll < 97) begin
      kind = REQ_READ;
      // mostly good indices, some at or past the end
      if (fill > 0 && $urandom_range(99) < 85) pos = POS_W'($urandom_range(fill - 1, 0));
      else                                    pos = POS_W'($urandom_range(127, fill));
    end else begin
      kind = REQ_UNUSED;
    end
  endtask

  // Result side: sample at the edge, so pre-edge values are seen.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      shadow.check_reply(out_read_data, out_count, out_status);
      replies_seen++;
    end
  end

  // Receiver stall pattern: runs of always-ready, coin-flip and sparse ready,
  // plus one long hold-off so the output register fills and in_ready drops.
  initial begin : drain_side
    int run;
    int mode;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!long_hold_done && replies_seen >= 200) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(2);
        run  = $urandom_range(40, 4);
        repeat (run) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(1));
            default: out_ready <= ($urandom_range(3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_insertable_array_store_top: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    req_t             kind;
    logic [POS_W-1:0] pos;
    word_t            val;
    int               sent;
    int               burst;
    int               gap;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_APPEND;
    in_position <= '0;
    in_value    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-store misses, unused kind, extreme words, insert at
    // front, at the end (acts as append) and in the middle, inserts past
    // the end, then reads across and just past the contents.
    send_request(REQ_READ,   7'd0,   32'sd0);
    send_request(REQ_READ,   7'd127, 32'sd0);
    send_request(REQ_INSERT, 7'd1,   32'sd5);
    send_request(REQ_UNUSED, 7'd127, -32'sd1);
    send_request(REQ_APPEND, 7'd127, 32'sh8000_0000);
    send_request(REQ_APPEND, 7'd0,   32'sh7fff_ffff);
    send_request(REQ_INSERT, 7'd0,   -32'sd1);
    send_request(REQ_INSERT, 7'd3,   32'sd0);
    send_request(REQ_INSERT, 7'd2,   32'sh1234_5678);
    send_request(REQ_INSERT, 7'd6,   32'sh5555_aaaa);
    send_request(REQ_INSERT, 7'd127, 32'sh2aaa_5555);
    for (int i = 0; i < 6; i++) send_request(REQ_READ, POS_W'(i), 32'sh7fff_ffff);
    send_request(REQ_READ,   7'd64,  32'sd0);
    send_request(REQ_UNUSED, 7'd0,   32'sd0);

    // Random part in bursts with gaps (sometimes none) between them.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(30, 1);
      repeat (burst) begin
        if (sent < RANDOM_REQS) begin
          pick_request(kind, pos, val);
          send_request(kind, pos, val);
          sent++;
        end
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain; the watchdog catches a reply that never comes.
    while (shadow.due_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (shadow.faults == 0) begin
      $display("tb_insertable_array_store_top: done, clean");
    end else begin
      $display("tb_insertable_array_store_top: done, errors");
    end
    $finish;
  end

endmodule

>>> insertable_array_store_top.f
+incdir+design
design/ias_pkg.sv
design/ias_cell.sv
design/ias_chain.sv
design/insertable_array_store_top.sv
test/tb_insertable_array_store_top.sv
